@@ hw/rtl/lrup_pkg.sv @@
package lrup_pkg;

  // number of frames built into the stack
  localparam int CAPACITY = 8;

  localparam int PAGE_W  = 16;
  localparam int TOTAL_W = 32;
  localparam int SIZE_W  = 4;
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } lrup_state_t;

  // control broadcast to every cell of the stack
  typedef struct packed {
    logic              update;
    logic              hit;
    logic [PAGE_W-1:0] page;
  } lrup_cell_ctl_t;

endpackage

@@ hw/rtl/lrup_if.sv @@
interface lrup_in_if;
  logic                       valid;
  logic                       ready;
  logic [lrup_pkg::PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lrup_out_if;
  logic                        valid;
  logic                        ready;
  logic                        was_fault;
  logic [lrup_pkg::PAGE_W-1:0]  entry_page;
  logic                        last_entry;
  logic [lrup_pkg::TOTAL_W-1:0] fault_total;

  modport source (output valid, output was_fault, output entry_page,
                  output last_entry, output fault_total, input ready);
  modport sink   (input valid, input was_fault, input entry_page,
                  input last_entry, input fault_total, output ready);
endinterface

@@ hw/rtl/lrup_cell.sv @@
module lrup_cell (
  input  logic                        clk,
  input  lrup_pkg::lrup_cell_ctl_t    ctl,
  input  logic                        is_head,
  input  logic                        held,
  input  logic                        in_range,
  input  logic [lrup_pkg::PAGE_W-1:0] prev_entry,
  input  logic                        tail_in,
  output logic                        tail_out,
  output logic [lrup_pkg::PAGE_W-1:0] entry
);

  logic match;
  logic shift;

  // match at this cell or any cell further down the stack
  assign match    = held && (entry == ctl.page);
  assign tail_out = tail_in | match;

  // hit: cells up to the hit position move down; miss: all cells of the new depth
  assign shift = ctl.update && (ctl.hit ? tail_out : in_range);

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= is_head ? ctl.page : prev_entry;
    end
  end

endmodule

@@ hw/rtl/lru_page_replacement.sv @@
// channel    dir  words per item        payload
// page_in    in   1                     page_number
// listing    out  1 .. CAPACITY         was_fault, entry_page, last_entry, fault_total
// cfg        in   write only, no wait   table_size (cfg_data)
//
// an accepted page updates the whole stack in the cycle it is taken; the listing
// then goes out one word a cycle while the sink does not stall, most recent first,
// one word per held entry (1 to CAPACITY), read through the single read port on
// the stack. a new page is taken in the cycle the last word leaves.
// rst is synchronous, active high: empties the stack, clears the fault count and
// sets table_size to 8. a stalled listing word holds until taken.
module lru_page_replacement (
  input  logic                             clk,
  input  logic                             rst,
  lrup_in_if.sink                          page_in,
  lrup_out_if.source                       listing,
  input  logic                             cfg_we,
  input  logic [lrup_pkg::SIZE_W-1:0]      cfg_data
);

  localparam int CAP = lrup_pkg::CAPACITY;

  // configuration and state
  logic [lrup_pkg::SIZE_W-1:0]  table_size;
  logic [lrup_pkg::CNT_W-1:0]   held;
  logic [lrup_pkg::CNT_W-1:0]   held_next;
  logic [lrup_pkg::TOTAL_W-1:0] fault_count;
  logic                         fault;
  logic [lrup_pkg::IDX_W-1:0]   idx;
  logic [lrup_pkg::IDX_W-1:0]   idx_next;
  lrup_pkg::lrup_state_t        state;
  lrup_pkg::lrup_state_t        state_next;

  // stack chain
  lrup_pkg::lrup_cell_ctl_t     ctl;
  logic [lrup_pkg::PAGE_W-1:0]  entry    [CAP];
  logic [CAP:0]                 tail;
  logic [CAP-1:0]               cell_held;
  logic [CAP-1:0]               cell_range;

  logic [lrup_pkg::CNT_W-1:0]   size;      // frames in use after clamping
  logic [lrup_pkg::CNT_W-1:0]   held_clip; // held count cut to the frame count
  logic [lrup_pkg::CNT_W-1:0]   held_miss; // count after a miss
  logic                         accept;
  logic                         word_done;
  logic                         at_last;
  logic                         hit;

  // frame count: zero reads as one, above capacity reads as capacity
  always_comb begin
    if (table_size == '0) begin
      size = lrup_pkg::CNT_W'(1);
    end else if (int'(table_size) > CAP) begin
      size = lrup_pkg::CNT_W'(CAP);
    end else begin
      size = lrup_pkg::CNT_W'(table_size);
    end
  end

  always_comb begin
    held_clip = (held > size) ? size : held;
    // a full table evicts the least recent entry before the push
    held_miss = (held_clip >= size) ? size : held_clip + lrup_pkg::CNT_W'(1);
  end

  // cell i takes part in the search below the clipped count, and in a miss
  // shift below the new count
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      cell_held[i]  = lrup_pkg::CNT_W'(i) < held_clip;
      cell_range[i] = lrup_pkg::CNT_W'(i) < held_miss;
    end
  end

  assign accept    = page_in.valid && page_in.ready;
  assign word_done = listing.valid && listing.ready;
  assign at_last   = (lrup_pkg::CNT_W'(idx) + lrup_pkg::CNT_W'(1)) == held;

  assign tail[CAP] = 1'b0;
  assign hit       = tail[0];

  assign ctl.update = accept;
  assign ctl.hit    = hit;
  assign ctl.page   = page_in.page_number;

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    lrup_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .is_head    (g == 0),
      .held       (cell_held[g]),
      .in_range   (cell_range[g]),
      .prev_entry ((g == 0) ? page_in.page_number : entry[(g == 0) ? 0 : g - 1]),
      .tail_in    (tail[g+1]),
      .tail_out   (tail[g]),
      .entry      (entry[g])
    );
  end

  // page taken when idle, or as the last word of the listing leaves
  assign page_in.ready = (state == lrup_pkg::ST_IDLE) ||
                         (state == lrup_pkg::ST_LIST && at_last && listing.ready);

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      lrup_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = lrup_pkg::ST_LIST;
          idx_next   = '0;
        end
      end
      lrup_pkg::ST_LIST: begin
        if (accept) begin
          idx_next = '0;
        end else if (word_done) begin
          if (at_last) begin
            state_next = lrup_pkg::ST_IDLE;
          end else begin
            idx_next = idx + lrup_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = lrup_pkg::ST_IDLE;
      end
    endcase
  end

  // listing outputs
  always_comb begin
    listing.valid       = 1'b0;
    listing.was_fault   = fault;
    listing.entry_page  = entry[idx];
    listing.last_entry  = at_last;
    listing.fault_total = fault_count;
    case (state)
      lrup_pkg::ST_IDLE: listing.valid = 1'b0;
      lrup_pkg::ST_LIST: listing.valid = 1'b1;
      default:           listing.valid = 1'b0;
    endcase
  end

  assign held_next = hit ? held_clip : held_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lrup_pkg::ST_IDLE;
      idx         <= '0;
      held        <= '0;
      fault_count <= '0;
      fault       <= 1'b0;
      table_size  <= lrup_pkg::SIZE_RESET;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cfg_we) begin
        table_size <= cfg_data;
      end
      if (accept) begin
        held  <= held_next;
        fault <= !hit;
        // saturating fault count
        if (!hit && fault_count != '1) begin
          fault_count <= fault_count + lrup_pkg::TOTAL_W'(1);
        end
      end
    end
  end

endmodule
